@@ hdl/shuffled_lcg_random_generator_core_assert.svh @@
// Assertion macros shared by the shuffled LCG generator RTL.
// Depends on nothing; files that check their own logic include this header.
`ifndef SHUFFLED_LCG_RANDOM_GENERATOR_CORE_ASSERT_SVH
`define SHUFFLED_LCG_RANDOM_GENERATOR_CORE_ASSERT_SVH

// Clocked check, off while reset is held.
`define SLCG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);

// Clocked check that also holds through reset.
`define SLCG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) (prop)) else $error(msg);

`endif

@@ hdl/slcg_pkg.sv @@
// Package for the shuffled LCG generator: widths, LCG constants, FSM state and
// the control/status structs between the top level and the modulo unit. No dependencies.
package slcg_pkg;

    localparam int TABLE_DEPTH = 103;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);

    localparam int VALUE_W = 63;
    localparam int SEED_W  = 64;
    localparam int HALF_W  = 32;
    localparam int MULT_W  = 30;
    localparam int PROD_W  = MULT_W + HALF_W;

    localparam logic [MULT_W-1:0]  LCG_MULT = 30'd892368405;
    localparam logic [VALUE_W-1:0] LCG_INC  = 63'd999;

    // Modulo unit works one byte per cycle over the value padded to 64 bits.
    localparam int DIGIT_W    = 8;
    localparam int MOD_DIGITS = (VALUE_W + DIGIT_W) / DIGIT_W;
    localparam int MOD_CNT_W  = $clog2(MOD_DIGITS);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MOD_WAIT,
        ST_READ,
        ST_WRITE,
        ST_FILL
    } state_t;

    typedef struct packed {
        logic start;
    } mod_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mod_status_t;

endpackage

@@ hdl/slcg_mod_unit.sv @@
// Byte-serial reduction of a 63-bit value modulo TABLE_DEPTH.
// Depends on slcg_pkg and the assertion header.
`include "shuffled_lcg_random_generator_core_assert.svh"

module slcg_mod_unit
    import slcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  mod_ctrl_t          ctrl,
    input  logic [VALUE_W-1:0] value,
    output mod_status_t        status,
    output logic [IDX_W-1:0]   rem
);

    localparam int WORK_W  = IDX_W + DIGIT_W;
    localparam int SHIFT_W = MOD_DIGITS * DIGIT_W;
    localparam logic [WORK_W-1:0] DEPTH_W = WORK_W'(TABLE_DEPTH);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [MOD_CNT_W-1:0] cnt_reg, cnt_next;
    logic [SHIFT_W-1:0]   shift_reg, shift_next;
    logic [IDX_W-1:0]     rem_reg, rem_next;
    logic [WORK_W-1:0]    work;

    always_comb begin
        busy_next  = busy_reg;
        done_next  = 1'b0;
        cnt_next   = cnt_reg;
        shift_next = shift_reg;
        rem_next   = rem_reg;

        // Remainder so far times 256 plus the next byte stays below 256*DEPTH,
        // so one conditional subtract per shifted copy of DEPTH is enough.
        work = {rem_reg, shift_reg[SHIFT_W-1 -: DIGIT_W]};
        for (int k = DIGIT_W - 1; k >= 0; k--) begin
            if (work >= (DEPTH_W << k)) begin
                work = work - (DEPTH_W << k);
            end
        end

        if (ctrl.start) begin
            busy_next  = 1'b1;
            cnt_next   = '0;
            rem_next   = '0;
            shift_next = SHIFT_W'(value);
        end else if (busy_reg) begin
            rem_next   = work[IDX_W-1:0];
            shift_next = shift_reg << DIGIT_W;
            cnt_next   = cnt_reg + 1'b1;
            if (cnt_reg == MOD_CNT_W'(MOD_DIGITS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        shift_reg <= shift_next;
        rem_reg   <= rem_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign rem         = rem_reg;

    `SLCG_ASSERT(a_rem_in_range, done_reg |-> (rem_reg <= IDX_W'(TABLE_DEPTH - 1)),
        "remainder out of table range")
    `SLCG_ASSERT(a_done_after_busy, done_reg |-> $past(busy_reg), "done without a running pass")
    `SLCG_ASSERT(a_busy_done_excl, !(busy_reg && done_reg), "busy and done together")

endmodule

@@ hdl/shuffled_lcg_random_generator_core.sv @@
// Shuffled LCG random generator: one request reseeds or draws one 0.63 fraction.
// A draw runs two passes of the shared 30x32 multiplier per LCG step, the byte-serial
// modulo unit and the capture of its remainder, then a registered table read and the table
// write. A reseed makes two multiplier passes and one table write per slot. No new
// request is taken until the last one is through. The table has a valid bit per entry
// cleared by reset, so no clearing pass follows reset and a slot never written reads as
// zero. A result waits in an output register while the next request is taken; a draw
// that finds the register still full holds until it drains.
// Depends on slcg_pkg, slcg_mod_unit and the assertion header.
`include "shuffled_lcg_random_generator_core_assert.svh"

module shuffled_lcg_random_generator_core
    import slcg_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_mode,
    input  logic [SEED_W-1:0]  s_seed,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [VALUE_W-1:0] m_fraction
);

    state_t               state_reg, state_next;
    logic                 draw_reg, draw_next;
    logic [VALUE_W-1:0]   gen_reg, gen_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0]   fraction_reg, fraction_next;

    logic [HALF_W-1:0]    mul_opnd;
    logic [PROD_W-1:0]    mul_res;
    logic [VALUE_W-1:0]   step_value;

    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic [VALUE_W-1:0]   table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] table_vld_reg;
    logic [VALUE_W-1:0]   rd_data_reg;
    logic                 rd_hit_reg;

    mod_ctrl_t            mod_ctrl;
    mod_status_t          mod_status;
    logic [IDX_W-1:0]     mod_rem;

    // Shared multiplier: low half of x first, then high half.
    assign mul_opnd = (state_reg == ST_MUL_LO) ? gen_reg[HALF_W-1:0]
                                                : HALF_W'(gen_reg[VALUE_W-1:HALF_W]);
    assign mul_res  = {{HALF_W{1'b0}}, LCG_MULT} * {{MULT_W{1'b0}}, mul_opnd};

    // Only the low bits of the high partial product survive mod 2^63.
    assign step_value = VALUE_W'({1'b0, prod_reg}
                        + {mul_res[VALUE_W-HALF_W-1:0], {HALF_W{1'b0}}}
                        + LCG_INC);

    always_comb begin
        state_next    = state_reg;
        draw_next     = draw_reg;
        gen_next      = gen_reg;
        prod_next     = prod_reg;
        idx_next      = idx_reg;
        slot_next     = slot_reg;
        fraction_next = fraction_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        mem_we        = 1'b0;
        mem_waddr     = slot_reg;
        mod_ctrl      = '0;
        s_ready       = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    draw_next  = s_mode;
                    idx_next   = '0;
                    state_next = ST_MUL_LO;
                    if (!s_mode) begin
                        gen_next = s_seed[VALUE_W-1:0];
                    end
                end
            end
            ST_MUL_LO: begin
                prod_next  = mul_res;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                gen_next = step_value;
                if (draw_reg) begin
                    mod_ctrl.start = 1'b1;
                    state_next     = ST_MOD_WAIT;
                end else begin
                    state_next = ST_FILL;
                end
            end
            ST_MOD_WAIT: begin
                if (mod_status.done) begin
                    slot_next  = mod_rem;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = ST_WRITE;
            end
            ST_WRITE: begin
                // Hold until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    mem_we        = 1'b1;
                    fraction_next = rd_hit_reg ? rd_data_reg : '0;
                    m_valid_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            ST_FILL: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                if (idx_reg == IDX_W'(TABLE_DEPTH - 1)) begin
                    state_next = ST_IDLE;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_MUL_LO;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
            gen_reg     <= '0;
            draw_reg    <= 1'b0;
            idx_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            gen_reg     <= gen_next;
            draw_reg    <= draw_next;
            idx_reg     <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg     <= prod_next;
        slot_reg     <= slot_next;
        fraction_reg <= fraction_next;
    end

    // Shuffle table: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            table_mem[mem_waddr] <= gen_reg;
        end
        if (state_reg == ST_READ) begin
            rd_data_reg <= table_mem[slot_reg];
            rd_hit_reg  <= table_vld_reg[slot_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            table_vld_reg <= '0;
        end else if (mem_we) begin
            table_vld_reg[mem_waddr] <= 1'b1;
        end
    end

    slcg_mod_unit u_mod (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctrl    (mod_ctrl),
        .value   (step_value),
        .status  (mod_status),
        .rem     (mod_rem)
    );

    assign m_valid    = m_valid_reg;
    assign m_fraction = fraction_reg;

    `SLCG_ASSERT(a_idle_mod_quiet, s_ready |-> !mod_status.busy, "modulo unit busy while ready")
    `SLCG_ASSERT(a_done_in_wait, mod_status.done |-> (state_reg == ST_MOD_WAIT),
        "modulo result outside wait state")
    `SLCG_ASSERT(a_fill_only_reseed, (state_reg == ST_FILL) |-> !draw_reg,
        "table fill during a draw")
    `SLCG_ASSERT(a_write_sets_valid, (mem_we && state_reg == ST_WRITE) |=> m_valid_reg,
        "draw finished without a result")

endmodule

@@ verif/slcg_tb_pkg.sv @@
`timescale 1ns / 100ps
// Request codes shared by the generator testbench's checker and top.
// No dependencies.
package slcg_tb_pkg;

    typedef enum logic {
        REQ_RESEED = 1'b0,
        REQ_DRAW   = 1'b1
    } request_mode_t;

endpackage

@@ verif/slcg_fraction_checker.sv @@
`timescale 1ns / 100ps
// Tracks the LCG value and the shuffle table on every accepted request, then compares
// each drawn fraction with the oldest one predicted. Depends on slcg_pkg and slcg_tb_pkg.
module slcg_fraction_checker
    import slcg_pkg::*;
    import slcg_tb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic               s_mode,
    input  logic [SEED_W-1:0]  s_seed,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [VALUE_W-1:0] m_fraction,
    output int                 error_count,
    output int                 fractions_pending
);

    localparam logic [63:0] LCG_MULTIPLIER = 64'd892368405;
    localparam logic [63:0] LCG_INCREMENT  = 64'd999;
    localparam int          REPORT_LIMIT   = 10;

    logic [VALUE_W-1:0] lcg_value;
    logic [VALUE_W-1:0] shuffle_slots [TABLE_DEPTH];
    logic [VALUE_W-1:0] predicted_fractions [$];

    // Product wraps at 64 bits; keeping the low 63 bits reduces it mod 2^63.
    function automatic logic [VALUE_W-1:0] lcg_advance(input logic [VALUE_W-1:0] x);
        logic [63:0] product;
        product = LCG_MULTIPLIER * {1'b0, x} + LCG_INCREMENT;
        return product[VALUE_W-1:0];
    endfunction

    always @(posedge aclk) begin : track_requests
        logic [VALUE_W-1:0] oldest;
        int                 slot;

        if (!aresetn) begin
            error_count = 0;
            lcg_value = '0;
            foreach (shuffle_slots[i]) shuffle_slots[i] = '0;
            predicted_fractions.delete();
        end else begin
            // Check the result first: it always belongs to an earlier draw.
            if (m_valid && m_ready) begin
                if (predicted_fractions.size() == 0) begin
                    error_count = error_count + 1;
                    if (error_count <= REPORT_LIMIT)
                        $display("%0t: unexpected fraction %h", $realtime, m_fraction);
                end else begin
                    oldest = predicted_fractions.pop_front();
                    if (m_fraction !== oldest) begin
                        error_count = error_count + 1;
                        if (error_count <= REPORT_LIMIT)
                            $display("%0t: fraction mismatch: expected %h, got %h",
                                     $realtime, oldest, m_fraction);
                    end
                end
            end

            if (s_valid && s_ready) begin
                if (s_mode == REQ_RESEED) begin
                    // Seed bit 63 drops out; refill every slot in order.
                    lcg_value = s_seed[VALUE_W-1:0];
                    for (int i = 0; i < TABLE_DEPTH; i++) begin
                        lcg_value = lcg_advance(lcg_value);
                        shuffle_slots[i] = lcg_value;
                    end
                end else begin
                    lcg_value = lcg_advance(lcg_value);
                    slot = int'(lcg_value % TABLE_DEPTH);
                    predicted_fractions.push_back(shuffle_slots[slot]);
                    shuffle_slots[slot] = lcg_value;
                end
            end
        end
        fractions_pending <= predicted_fractions.size();
    end

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the shuffled LCG generator testbench: clock, reset, request stimulus and
// result-side stalls. Depends on slcg_pkg, slcg_tb_pkg and slcg_fraction_checker.
module tb_top
    import slcg_pkg::*;
    import slcg_tb_pkg::*;
();

    localparam int PHASE_REQUESTS = 383;
    localparam int SETTLE_CYCLES  = 4 * TABLE_DEPTH;

    logic               aclk = 1'b0;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic               s_mode;
    logic [SEED_W-1:0]  s_seed;
    logic               m_valid;
    logic               m_ready;
    logic [VALUE_W-1:0] m_fraction;

    int error_count;
    int fractions_pending;
    int sender_idle_pct;
    int receiver_stall_pct;

    int idle_pct_by_phase  [4] = '{0, 67, 0, 7};
    int stall_pct_by_phase [4] = '{0, 0, 67, 7};

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    shuffled_lcg_random_generator_core u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_mode     (s_mode),
        .s_seed     (s_seed),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_fraction (m_fraction)
    );

    slcg_fraction_checker u_checker (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_mode            (s_mode),
        .s_seed            (s_seed),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_fraction        (m_fraction),
        .error_count       (error_count),
        .fractions_pending (fractions_pending)
    );

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Idle at random, then hold the request until it is accepted.
    task automatic push_request(input request_mode_t mode, input logic [SEED_W-1:0] seed);
        while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_seed  <= seed;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and wait for every predicted fraction to arrive.
    task automatic hold_until_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (fractions_pending != 0);
    endtask

    function automatic logic [SEED_W-1:0] random_seed();
        case ($urandom_range(7))
            0:       return '1;
            1:       return '0;
            2:       return {1'b1, {(SEED_W-1){1'b0}}};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    initial begin
        #40_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_mode  <= REQ_DRAW;
        s_seed  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Draws on the cleared table return zero; the seed is ignored.
        push_request(REQ_DRAW, '0);
        push_request(REQ_DRAW, '1);
        push_request(REQ_DRAW, 64'h5555_AAAA_5555_AAAA);
        push_request(REQ_RESEED, '0);
        push_request(REQ_DRAW, '0);
        push_request(REQ_DRAW, '1);
        push_request(REQ_RESEED, '1);
        push_request(REQ_DRAW, '0);
        push_request(REQ_DRAW, '0);
        // Top seed bit alone must act like seed zero.
        push_request(REQ_RESEED, {1'b1, {(SEED_W-1){1'b0}}});
        push_request(REQ_DRAW, '0);
        push_request(REQ_DRAW, '0);
        push_request(REQ_RESEED, {1'b0, {(SEED_W-1){1'b1}}});
        push_request(REQ_DRAW, '0);
        push_request(REQ_DRAW, '0);
        // Back-to-back reseeds: only the last one counts.
        push_request(REQ_RESEED, 64'd1);
        push_request(REQ_RESEED, 64'd2);
        push_request(REQ_DRAW, '0);
        hold_until_drained();

        for (int phase = 0; phase < 4; phase++) begin
            sender_idle_pct    = idle_pct_by_phase[phase];
            receiver_stall_pct = stall_pct_by_phase[phase];
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (n == PHASE_REQUESTS / 2)
                    hold_until_drained();
                push_request(request_mode_t'(($urandom_range(19) == 0) ? REQ_RESEED : REQ_DRAW),
                             random_seed());
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (error_count == 0 && fractions_pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

@@ shuffled_lcg_random_generator_core.f @@
+incdir+hdl
hdl/slcg_pkg.sv
hdl/slcg_mod_unit.sv
hdl/shuffled_lcg_random_generator_core.sv
verif/slcg_tb_pkg.sv
verif/slcg_fraction_checker.sv
verif/tb_top.sv
